// ===== rtl/pcd_pkg.sv =====
// Package for the polyline cumulative distance block.
// Shared widths, constants and controller/datapath command and status types.
`timescale 1ns / 1ps
`default_nettype none
package pcd_pkg;
  localparam int CoordW     = 24;
  localparam int SqW        = 49;
  localparam int SegW       = 25;
  localparam int TotalW     = 31;
  localparam int FracW      = 17;
  localparam int DefMaxPts  = 63;
  localparam int SegDepth   = 64;
  localparam int SegAw      = 6;
  localparam int CountW     = 7;
  localparam int SqrtSteps  = 25;
  localparam int DivSteps   = 17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_first;    // capture the point as first and previous
    logic load_seg;      // start the square-difference for a new segment
    logic load_close;    // start the square-difference for closing segment
    logic sqrt_start;    // start the root unit
    logic sqrt_step;     // one root iteration
    logic seg_write;     // store the segment length and add it to the total
    logic sum_clear;     // clear cumulative sum for emission
    logic seg_read;      // issue a read of the segment store
    logic sum_add;       // add the read length to the cumulative sum
    logic div_start;     // start the divider
    logic div_step;      // one divider iteration
    logic line_clear;    // clear the per-line state
  } pcd_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic total_zero;
  } pcd_sts_t;
endpackage
`default_nettype wire

// ===== rtl/pcd_if.sv =====
// Valid/ready channel interfaces for the polyline cumulative distance block.
// Depends on pcd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface pcd_in_if import pcd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic                     is_last;
  logic                     closed;
  modport source (output valid, point_x, point_y, is_last, closed, input ready);
  modport sink (input valid, point_x, point_y, is_last, closed, output ready);
endinterface

interface pcd_out_if import pcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FracW-1:0] cumul_fraction;
  logic             run_last;
  modport source (output valid, cumul_fraction, run_last, input ready);
  modport sink (input valid, cumul_fraction, run_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/polyline_cumulative_distance.sv =====
// Top level of the polyline normalized cumulative distance block.
// Uses pcd_pkg, pcd_if, pcd_ctrl and pcd_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Points enter one at a time; each point after the first is held off while
// the 25-step bit-pair square root measures its segment. After the last
// point (plus one more root for a closed line) the block emits a zero and
// then one fraction per segment, each needing a segment store read and the
// 17-step restoring divider. No new point is taken during emission.
module polyline_cumulative_distance import pcd_pkg::*; #(
  parameter int MaxPoints = DefMaxPts
) (
  input wire logic clk,
  input wire logic rst_n,
  pcd_in_if.sink   in_ch,
  pcd_out_if.source out_ch
);
  pcd_cmd_t         cmd;
  pcd_sts_t         sts;
  logic [SegAw-1:0] waddr, raddr;

  pcd_ctrl #(.MaxPoints(MaxPoints)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_last(in_ch.is_last), .in_closed(in_ch.closed),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_run_last(out_ch.run_last),
    .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd), .waddr(waddr), .raddr(raddr)
  );

  pcd_datapath u_dp (
    .clk(clk), .pt_x(in_ch.point_x), .pt_y(in_ch.point_y),
    .cmd(cmd), .waddr(waddr), .raddr(raddr), .sts(sts),
    .frac(out_ch.cumul_fraction)
  );
endmodule
`default_nettype wire

// ===== rtl/pcd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/pcd_datapath.sv =====
// Datapath: point registers, squared distance, iterative root, segment
// store, running total and iterative fraction divider. Uses pcd_pkg, pcd_ram.
`timescale 1ns / 1ps
`default_nettype none
module pcd_datapath import pcd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [CoordW-1:0] pt_x,
  input  wire logic signed [CoordW-1:0] pt_y,
  input  wire pcd_cmd_t                 cmd,
  input  wire logic [SegAw-1:0]         waddr,
  input  wire logic [SegAw-1:0]         raddr,
  output      pcd_sts_t                 sts,
  output      logic [FracW-1:0]         frac
);
  logic signed [CoordW-1:0] fx_r, fy_r, px_r, py_r;
  logic [CoordW:0]          dx_r, dy_r;
  logic [SqW:0]             sq_r;
  logic [SqW-1:0]           rem_r;
  logic [SegW-1:0]          root_r;
  logic [TotalW-1:0]        total_r;
  logic [SegW-1:0]          rd_data;
  logic [TotalW:0]          cum_r;
  logic [TotalW+1:0]        drem_r;
  logic [FracW-1:0]         q_r;
  logic [TotalW-1:0]        cum_hold_r;
  logic [4:0]               sq_phase_r;
  logic signed [CoordW:0]   dxs, dys;
  logic [SqW+1:0]           trial;
  logic [SqW+1:0]           rem_sh;
  logic [TotalW+1:0]        dtrial;

  // Absolute coordinate differences for the next segment.
  always_comb begin
    if (cmd.load_close) begin
      dxs = {fx_r[CoordW-1], fx_r} - {px_r[CoordW-1], px_r};
      dys = {fy_r[CoordW-1], fy_r} - {py_r[CoordW-1], py_r};
    end else begin
      dxs = {pt_x[CoordW-1], pt_x} - {px_r[CoordW-1], px_r};
      dys = {pt_y[CoordW-1], pt_y} - {py_r[CoordW-1], py_r};
    end
  end

  // One restoring root step: bring down two bits, try 4r+1. The sum of
  // squares is held in an even number of bits so the pairs line up.
  assign rem_sh = {rem_r, sq_r[SqW -: 2]} & {(SqW+2){1'b1}};
  assign trial  = rem_sh - {({(SqW+2){1'b0}} | {root_r, 2'b01})};
  // One restoring divide step.
  assign dtrial = {drem_r[TotalW:0], cum_hold_r[TotalW-1]} - {2'b00, total_r};

  always_ff @(posedge clk) begin
    // Point capture.
    if (cmd.load_first) begin
      fx_r <= pt_x; fy_r <= pt_y; px_r <= pt_x; py_r <= pt_y;
    end
    if (cmd.load_seg) begin
      px_r <= pt_x; py_r <= pt_y;
    end
    if (cmd.load_seg || cmd.load_close) begin
      dx_r <= dxs[CoordW] ? (CoordW+1)'(0) - dxs : dxs;
      dy_r <= dys[CoordW] ? (CoordW+1)'(0) - dys : dys;
      sq_phase_r <= '0;
    end
    // Sum of squares, one product per cycle.
    if (cmd.sqrt_start) begin
      if (sq_phase_r == 5'd0) begin
        sq_r <= (SqW+1)'(dx_r * dx_r);
        sq_phase_r <= 5'd1;
      end else begin
        sq_r <= sq_r + (SqW+1)'(dy_r * dy_r);
        rem_r <= '0;
        root_r <= '0;
        sq_phase_r <= 5'd0;
      end
    end
    // Root iteration.
    if (cmd.sqrt_step) begin
      sq_r <= {sq_r[SqW-2:0], 2'b00};
      if (!trial[SqW+1]) begin
        rem_r <= trial[SqW-1:0];
        root_r <= {root_r[SegW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[SqW-1:0];
        root_r <= {root_r[SegW-2:0], 1'b0};
      end
    end
    // Running total.
    if (cmd.line_clear) total_r <= '0;
    else if (cmd.seg_write) total_r <= total_r + TotalW'(root_r);
    // Cumulative sum during emission.
    if (cmd.sum_clear) cum_r <= '0;
    else if (cmd.sum_add) cum_r <= cum_r + (TotalW+1)'(rd_data);
    // Fraction divider: (cum << 16) / total, 17 quotient bits. The partial
    // remainder starts at cum >> 1 and the last dividend bits are cum[0]
    // followed by zeros. The quotient reads zero for the leading result.
    if (cmd.div_start) begin
      drem_r <= (TotalW+2)'(cum_r[TotalW:1]);
      cum_hold_r <= {cum_r[0], {(TotalW-1){1'b0}}};
      q_r <= '0;
    end else if (cmd.div_step) begin
      cum_hold_r <= {cum_hold_r[TotalW-2:0], 1'b0};
      if (!dtrial[TotalW+1]) begin
        drem_r <= dtrial;
        q_r <= {q_r[FracW-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[TotalW:0], cum_hold_r[TotalW-1]};
        q_r <= {q_r[FracW-2:0], 1'b0};
      end
    end else if (cmd.sum_clear) begin
      q_r <= '0;
    end
  end

  pcd_ram #(.Width(SegW), .Depth(SegDepth)) u_seg_ram (
    .clk(clk), .we(cmd.seg_write), .waddr(waddr), .wdata(root_r),
    .raddr(raddr), .rdata(rd_data)
  );

  assign sts.total_zero = (total_r == '0);
  assign frac = sts.total_zero ? '0 : q_r;
endmodule
`default_nettype wire

// ===== rtl/pcd_ctrl.sv =====
// Controller: sequences point intake, segment roots and fraction emission.
// Uses pcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcd_ctrl import pcd_pkg::*; #(
  parameter int MaxPoints = DefMaxPts
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_last,
  input  wire logic             in_closed,
  output      logic             in_ready,
  output      logic             out_valid,
  output      logic             out_run_last,
  input  wire logic             out_ready,
  input  wire pcd_sts_t         sts,
  output      pcd_cmd_t         cmd,
  output      logic [SegAw-1:0] waddr,
  output      logic [SegAw-1:0] raddr
);
  typedef enum logic [3:0] {
    S_IDLE, S_SQ0, S_SQ1, S_ROOT, S_WRITE, S_ZERO, S_READ, S_WAITRD,
    S_ADD, S_DIVST, S_DIV, S_EMIT
  } state_t;

  state_t            state_r;
  logic [CountW-1:0] count_r;
  logic [SegAw-1:0]  idx_r;
  logic [CountW-1:0] nseg_r;
  logic [4:0]        step_r;
  logic              last_r, close_r, closing_r;
  logic              out_valid_r, out_last_r;
  logic              acc;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_run_last = out_last_r;
  assign waddr = idx_r;
  assign raddr = idx_r;

  // Commands decoded from the state.
  always_comb begin
    cmd = '0;
    cmd.load_first = acc && (count_r == '0);
    cmd.load_seg   = acc && (count_r != '0) && (count_r < CountW'(MaxPoints));
    cmd.load_close = (state_r == S_ZERO) && close_r && !closing_r;
    cmd.sqrt_start = (state_r == S_SQ0) || (state_r == S_SQ1);
    cmd.sqrt_step  = (state_r == S_ROOT);
    cmd.seg_write  = (state_r == S_WRITE);
    cmd.sum_clear  = (state_r == S_ZERO);
    cmd.sum_add    = (state_r == S_ADD);
    cmd.div_start  = (state_r == S_DIVST);
    cmd.div_step   = (state_r == S_DIV);
    cmd.line_clear = !rst_n || ((state_r == S_EMIT) && out_ready && out_last_r);
    cmd.seg_read   = (state_r == S_READ);
  end

  // State, counters and registered output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r <= '0;
      nseg_r <= '0;
      step_r <= '0;
      last_r <= 1'b0;
      close_r <= 1'b0;
      closing_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (acc) begin
          last_r <= in_last;
          close_r <= in_closed;
          closing_r <= 1'b0;
          if (count_r < CountW'(MaxPoints)) begin
            count_r <= count_r + 1'b1;
            idx_r <= SegAw'(count_r - 1'b1);
          end
          if (count_r != '0 && count_r < CountW'(MaxPoints)) state_r <= S_SQ0;
          else if (in_last) state_r <= S_ZERO;
        end
        S_SQ0: state_r <= S_SQ1;
        S_SQ1: begin
          step_r <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          step_r <= step_r + 1'b1;
          if (step_r == 5'(SqrtSteps - 1)) state_r <= S_WRITE;
        end
        S_WRITE: state_r <= (last_r || closing_r) ? S_ZERO : S_IDLE;
        S_ZERO: begin
          // Closing segment first, then the leading zero result.
          if (close_r && !closing_r) begin
            closing_r <= 1'b1;
            idx_r <= SegAw'(count_r - 1'b1);
            if (count_r == '0) idx_r <= '0;
            state_r <= S_SQ0;
          end else if (!out_valid_r) begin
            nseg_r <= (count_r == '0 ? '0 : count_r - 1'b1) +
                      CountW'(closing_r);
            out_valid_r <= 1'b1;
            out_last_r <= ((count_r == '0 ? '0 : count_r - 1'b1) +
                           CountW'(closing_r)) == '0;
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
            idx_r <= '0;
            if (out_last_r) begin
              out_last_r <= 1'b0;
              count_r <= '0;
              state_r <= S_IDLE;
            end else state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_WAITRD;
        S_WAITRD: state_r <= S_ADD;
        S_ADD: state_r <= S_DIVST;
        S_DIVST: begin
          step_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == 5'(DivSteps - 1)) begin
            out_valid_r <= 1'b1;
            out_last_r <= (CountW'(idx_r) + 1'b1) == nseg_r;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: if (out_ready) begin
          out_valid_r <= 1'b0;
          if (out_last_r) begin
            out_last_r <= 1'b0;
            count_r <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = sts.total_zero;
endmodule
`default_nettype wire

// ===== rtl/pcd_checker.sv =====
// Port-level checker for the polyline cumulative distance block.
// Bound to the top level; uses pcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcd_checker import pcd_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [FracW-1:0] out_fraction,
  input wire logic out_run_last
);
  // Points are not taken while a result waits.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  // A fraction never exceeds one.
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fraction <= FracW'(65536)) else $error("fraction above one");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fraction))
    else $error("result dropped");
  // After the final result the block takes points again.
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_run_last |=> in_ready)
    else $error("not ready after line");
  // An offered point stays offered until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("point withdrawn before it was taken");
endmodule

bind polyline_cumulative_distance pcd_checker u_pcd_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_fraction(out_ch.cumul_fraction), .out_run_last(out_ch.run_last)
);
`default_nettype wire
